>>> rtl/assert_macros.svh
// assertion helpers for the tokenizer block
// every assertion is clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define TOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in a cycle implies consequent in the next
`define TOK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cltok_pkg.sv
// shared types, codes and character tables for the c-like tokenizer
// no dependencies
`default_nettype none

package cltok_pkg;

  localparam int OFFSET_BITS      = 32;
  localparam int TOKEN_INDEX_BITS = 32;
  localparam int RESULT_SLOTS     = 3;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  typedef enum logic [1:0] {
    RK_TOKEN = 2'd0,
    RK_SPAN  = 2'd1,
    RK_ERROR = 2'd2
  } result_kind_e;

  typedef enum logic [3:0] {
    TK_IDENT     = 4'd0,
    TK_NAMESPACE = 4'd1,
    TK_ENUM      = 4'd2,
    TK_CLASS     = 4'd3,
    TK_STRUCT    = 4'd4,
    TK_INT       = 4'd5,
    TK_STRING    = 4'd6,
    TK_PUNCT     = 4'd7,
    TK_EOF       = 4'd8
  } token_kind_e;

  typedef enum logic [1:0] {
    EC_INVALID  = 2'd0,
    EC_STRING   = 2'd1,
    EC_COMMENT  = 2'd2,
    EC_OVERFLOW = 2'd3
  } error_code_e;

  localparam logic [3:0] PC_NONE = 4'd0;
  localparam logic [3:0] PC_HASH = 4'd9;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  // keywords left aligned, first character in the top byte
  localparam logic [71:0] KW_NAMESPACE = "namespace";
  localparam logic [71:0] KW_ENUM      = {"enum", 40'h0};
  localparam logic [71:0] KW_CLASS     = {"class", 32'h0};
  localparam logic [71:0] KW_STRUCT    = {"struct", 24'h0};

  typedef struct packed {
    result_kind_e                kind;
    token_kind_e                 tkind;
    logic [3:0]                  pcode;
    logic [OFFSET_BITS-1:0]      start;
    logic [OFFSET_BITS-1:0]      len;
    logic                        bol;
    logic [TOKEN_INDEX_BITS-1:0] dfirst;
    logic [TOKEN_INDEX_BITS-1:0] dend;
    error_code_e                 ecode;
  } result_t;

  function automatic logic [71:0] kw_text(input logic [1:0] k);
    logic [71:0] s;
    unique case (k)
      2'd0:    s = KW_NAMESPACE;
      2'd1:    s = KW_ENUM;
      2'd2:    s = KW_CLASS;
      default: s = KW_STRUCT;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    logic [3:0] l;
    unique case (k)
      2'd0:    l = 4'd9;
      2'd1:    l = 4'd4;
      2'd2:    l = 4'd5;
      default: l = 4'd6;
    endcase
    return l;
  endfunction

  function automatic logic [3:0] punct_code(input logic [7:0] c);
    logic [3:0] p;
    unique case (c)
      8'h7b:   p = 4'd1;   // {
      8'h7d:   p = 4'd2;   // }
      8'h3b:   p = 4'd3;   // ;
      8'h3a:   p = 4'd4;   // :
      8'h2c:   p = 4'd5;   // ,
      8'h3d:   p = 4'd6;   // =
      8'h2b:   p = 4'd7;   // +
      8'h2d:   p = 4'd8;   // -
      8'h23:   p = PC_HASH;
      8'h26:   p = 4'd10;  // &
      8'h2a:   p = 4'd11;  // *
      8'h5b:   p = 4'd12;  // [
      8'h5d:   p = 4'd13;  // ]
      default: p = PC_NONE;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> rtl/c_like_source_tokenizer.sv
// c-like tokenizer: one source byte or end item in, up to three result items out
// results of an item appear in the cycle after it is accepted, one result a cycle while
// out_stall_i is low; throughput: one item per cycle while each item gives at most one
// result and out_stall_i is low; more results hold the input until the last is taken
// reset: async active low, scanner idle at offset 0, directives enabled, buffer empty
// depends on cltok_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module c_like_source_tokenizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_source_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [3:0]       token_kind_o,
  output logic [3:0]       punctuation_code_o,
  output logic [31:0]      start_offset_o,
  output logic [31:0]      span_length_o,
  output logic             at_line_start_o,
  output logic [31:0]      directive_first_o,
  output logic [31:0]      directive_end_o,
  output logic [1:0]       error_code_o,
  output logic             last_o
);

  localparam int OB = cltok_pkg::OFFSET_BITS;
  localparam int TB = cltok_pkg::TOKEN_INDEX_BITS;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_IDENT, MODE_INT, MODE_STRING, MODE_SLASH,
    MODE_LINE, MODE_BLOCK, MODE_BSTAR, MODE_HALT
  } mode_e;

  // scanner state
  mode_e             mode_q, mode_d;
  logic [OB-1:0]     pos_q, pos_d;
  logic [OB-1:0]     pstart_q, pstart_d;
  logic              lsf_q, lsf_d;
  logic              pls_q, pls_d;
  logic              dopen_q, dopen_d;
  logic [TB-1:0]     dbeg_q, dbeg_d;
  logic [TB-1:0]     ntok_q, ntok_d;
  logic [3:0]        kwc_q, kwc_d;
  logic [3:0]        ilen_q, ilen_d;
  logic              dir_en_q;

  // result buffer
  cltok_pkg::result_t res_q [cltok_pkg::RESULT_SLOTS];
  cltok_pkg::result_t res_d [cltok_pkg::RESULT_SLOTS];
  logic [1:0]        cnt_q, cnt_d;
  logic [1:0]        head_q, head_d;
  logic [1:0]        nres_d;

  logic              in_take, out_take, out_last, buf_free;
  cltok_pkg::result_t out_res;

  function automatic cltok_pkg::result_t tok_res(cltok_pkg::token_kind_e tk, logic [3:0] pc,
                                                 logic [OB-1:0] st, logic [OB-1:0] ln,
                                                 logic ls);
    cltok_pkg::result_t r;
    r       = cltok_pkg::result_t'('0);
    r.kind  = cltok_pkg::RK_TOKEN;
    r.tkind = tk;
    r.pcode = pc;
    r.start = st;
    r.len   = ln;
    r.bol   = ls;
    return r;
  endfunction

  function automatic cltok_pkg::result_t err_res(cltok_pkg::error_code_e ec,
                                                 logic [OB-1:0] st, logic [OB-1:0] ln);
    cltok_pkg::result_t r;
    r       = cltok_pkg::result_t'('0);
    r.kind  = cltok_pkg::RK_ERROR;
    r.ecode = ec;
    r.start = st;
    r.len   = ln;
    return r;
  endfunction

  function automatic cltok_pkg::result_t span_res(logic [TB-1:0] first, logic [TB-1:0] last);
    cltok_pkg::result_t r;
    r        = cltok_pkg::result_t'('0);
    r.kind   = cltok_pkg::RK_SPAN;
    r.dfirst = first;
    r.dend   = last;
    return r;
  endfunction

  // drop keyword candidates that the next identifier character rules out
  function automatic logic [3:0] kw_filter(logic [3:0] kwc, logic [3:0] ilen, logic [7:0] c);
    logic [3:0]  m;
    logic [71:0] s;
    logic [7:0]  ch;
    m = kwc;
    for (int k = 0; k < 4; k++) begin
      s  = cltok_pkg::kw_text(2'(k));
      ch = 8'h00;
      for (int j = 0; j < 9; j++) begin
        if (ilen == 4'(j)) ch = s[71-8*j -: 8];
      end
      if (ilen >= cltok_pkg::kw_len(2'(k)) || ch != c) m[k] = 1'b0;
    end
    return m;
  endfunction

  function automatic cltok_pkg::token_kind_e word_kind(logic ident, logic [3:0] kwc,
                                                       logic [3:0] ilen);
    cltok_pkg::token_kind_e tk;
    tk = ident ? cltok_pkg::TK_IDENT : cltok_pkg::TK_INT;
    if (ident) begin
      for (int k = 0; k < 4; k++) begin
        if (kwc[k] && ilen == cltok_pkg::kw_len(2'(k)))
          tk = cltok_pkg::token_kind_e'(4'(k + 1));
      end
    end
    return tk;
  endfunction

  logic is_alpha, is_digit;
  assign is_alpha = (data_byte_i >= 8'h61 && data_byte_i <= 8'h7a) ||
                    (data_byte_i >= 8'h41 && data_byte_i <= 8'h5a) || data_byte_i == 8'h5f;
  assign is_digit = data_byte_i >= 8'h30 && data_byte_i <= 8'h39;

  always_comb begin
    logic       do_idle;
    logic [3:0] pc;
    mode_d   = mode_q;
    pos_d    = pos_q;
    pstart_d = pstart_q;
    lsf_d    = lsf_q;
    pls_d    = pls_q;
    dopen_d  = dopen_q;
    dbeg_d   = dbeg_q;
    ntok_d   = ntok_q;
    kwc_d    = kwc_q;
    ilen_d   = ilen_q;
    nres_d   = 2'd0;
    do_idle  = 1'b0;
    pc       = cltok_pkg::punct_code(data_byte_i);
    for (int i = 0; i < cltok_pkg::RESULT_SLOTS; i++) res_d[i] = cltok_pkg::result_t'('0);

    if (end_of_source_i) begin
      unique case (mode_q)
        MODE_IDENT, MODE_INT: begin
          res_d[nres_d] = tok_res(word_kind(mode_q == MODE_IDENT, kwc_q, ilen_q), cltok_pkg::PC_NONE,
                                  pstart_q, pos_q - pstart_q, pls_q);
          nres_d = nres_d + 2'd1;
          ntok_d = ntok_d + TB'(1);
          mode_d = MODE_IDLE;
        end
        MODE_STRING: begin
          res_d[nres_d] = err_res(cltok_pkg::EC_STRING, pstart_q, pos_q - pstart_q);
          nres_d = nres_d + 2'd1;
          mode_d = MODE_HALT;
        end
        MODE_SLASH: begin
          res_d[nres_d] = err_res(cltok_pkg::EC_INVALID, pstart_q, OB'(1));
          nres_d = nres_d + 2'd1;
          mode_d = MODE_HALT;
        end
        MODE_BLOCK, MODE_BSTAR: begin
          res_d[nres_d] = err_res(cltok_pkg::EC_COMMENT, pstart_q, pos_q - pstart_q);
          nres_d = nres_d + 2'd1;
          mode_d = MODE_HALT;
        end
        default: ;
      endcase
      if (mode_d != MODE_HALT) begin
        if (dopen_q && dir_en_q) begin
          res_d[nres_d] = span_res(dbeg_q, ntok_d);
          nres_d = nres_d + 2'd1;
        end
        res_d[nres_d] = tok_res(cltok_pkg::TK_EOF, cltok_pkg::PC_NONE, pos_q, '0, 1'b0);
        nres_d = nres_d + 2'd1;
      end
      // next source starts from scratch
      mode_d   = MODE_IDLE;
      pos_d    = '0;
      pstart_d = '0;
      lsf_d    = 1'b1;
      pls_d    = 1'b0;
      dopen_d  = 1'b0;
      dbeg_d   = '0;
      ntok_d   = '0;
      kwc_d    = '0;
      ilen_d   = '0;
    end else if (mode_q != MODE_HALT) begin
      if (pos_q == cltok_pkg::OFFSET_MAX) begin
        res_d[nres_d] = err_res(cltok_pkg::EC_OVERFLOW, '0, '0);
        nres_d = nres_d + 2'd1;
        mode_d = MODE_HALT;
      end else begin
        unique case (mode_q)
          MODE_IDENT, MODE_INT: begin
            if (mode_q == MODE_IDENT && (is_alpha || is_digit)) begin
              kwc_d  = kw_filter(kwc_q, ilen_q, data_byte_i);
              ilen_d = (ilen_q == 4'd15) ? ilen_q : ilen_q + 4'd1;
            end else if (!(mode_q == MODE_INT && is_digit)) begin
              res_d[nres_d] = tok_res(word_kind(mode_q == MODE_IDENT, kwc_q, ilen_q),
                                      cltok_pkg::PC_NONE, pstart_q, pos_q - pstart_q, pls_q);
              nres_d  = nres_d + 2'd1;
              ntok_d  = ntok_d + TB'(1);
              mode_d  = MODE_IDLE;
              do_idle = 1'b1;
            end
          end
          MODE_STRING: begin
            if (data_byte_i == cltok_pkg::CH_QUOTE) begin
              mode_d = MODE_IDLE;
              res_d[nres_d] = tok_res(cltok_pkg::TK_STRING, cltok_pkg::PC_NONE, pstart_q,
                                      pos_q + OB'(1) - pstart_q, pls_q);
              nres_d = nres_d + 2'd1;
              ntok_d = ntok_d + TB'(1);
            end else if (data_byte_i == cltok_pkg::CH_LF) begin
              res_d[nres_d] = err_res(cltok_pkg::EC_STRING, pstart_q, pos_q - pstart_q);
              nres_d = nres_d + 2'd1;
              mode_d = MODE_HALT;
            end
          end
          MODE_SLASH: begin
            if (data_byte_i == cltok_pkg::CH_SLASH) begin
              mode_d = MODE_LINE;
            end else if (data_byte_i == cltok_pkg::CH_STAR) begin
              mode_d = MODE_BLOCK;
            end else begin
              res_d[nres_d] = err_res(cltok_pkg::EC_INVALID, pstart_q, OB'(1));
              nres_d = nres_d + 2'd1;
              mode_d = MODE_HALT;
            end
          end
          MODE_LINE: begin
            if (data_byte_i == cltok_pkg::CH_LF) begin
              mode_d  = MODE_IDLE;
              do_idle = 1'b1;
            end
          end
          MODE_BLOCK, MODE_BSTAR: begin
            if (mode_q == MODE_BSTAR && data_byte_i == cltok_pkg::CH_SLASH) begin
              mode_d = MODE_IDLE;
            end else if (data_byte_i == cltok_pkg::CH_STAR) begin
              mode_d = MODE_BSTAR;
            end else begin
              if (data_byte_i == cltok_pkg::CH_LF) lsf_d = 1'b1;
              mode_d = MODE_BLOCK;
            end
          end
          default: do_idle = 1'b1;
        endcase

        // byte seen between tokens
        if (do_idle) begin
          priority if (data_byte_i == cltok_pkg::CH_SPACE || data_byte_i == cltok_pkg::CH_TAB ||
                       data_byte_i == cltok_pkg::CH_CR) begin
          end else if (data_byte_i == cltok_pkg::CH_LF) begin
            if (dopen_d && dir_en_q) begin
              res_d[nres_d] = span_res(dbeg_d, ntok_d);
              nres_d = nres_d + 2'd1;
            end
            dopen_d = 1'b0;
            lsf_d   = 1'b1;
          end else if (data_byte_i == cltok_pkg::CH_SLASH) begin
            mode_d   = MODE_SLASH;
            pstart_d = pos_q;
          end else begin
            pstart_d = pos_q;
            pls_d    = lsf_d;
            priority if (is_alpha) begin
              lsf_d  = 1'b0;
              mode_d = MODE_IDENT;
              kwc_d  = kw_filter(4'hf, 4'd0, data_byte_i);
              ilen_d = 4'd1;
            end else if (is_digit) begin
              lsf_d  = 1'b0;
              mode_d = MODE_INT;
            end else if (data_byte_i == cltok_pkg::CH_QUOTE) begin
              lsf_d  = 1'b0;
              mode_d = MODE_STRING;
            end else if (pc != cltok_pkg::PC_NONE) begin
              lsf_d = 1'b0;
              // hash first on its line opens a directive at the current token index when enabled
              if (pc == cltok_pkg::PC_HASH && pls_d && dir_en_q) begin
                dbeg_d  = ntok_d;
                dopen_d = 1'b1;
              end
              res_d[nres_d] = tok_res(cltok_pkg::TK_PUNCT, pc, pos_q, OB'(1), pls_d);
              nres_d = nres_d + 2'd1;
              ntok_d = ntok_d + TB'(1);
            end else begin
              res_d[nres_d] = err_res(cltok_pkg::EC_INVALID, pos_q, OB'(1));
              nres_d = nres_d + 2'd1;
              mode_d = MODE_HALT;
            end
          end
        end
        pos_d = pos_q + OB'(1);
      end
    end
  end

  // result buffer control
  assign out_valid_o = cnt_q != 2'd0;
  assign out_take    = out_valid_o && !out_stall_i;
  assign out_last    = head_q + 2'd1 == cnt_q;
  assign buf_free    = cnt_q == 2'd0 || (out_take && out_last);
  assign in_stall_o  = !buf_free;
  assign in_take     = in_valid_i && buf_free;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    if (in_take) begin
      cnt_d  = nres_d;
      head_d = 2'd0;
    end else if (out_take) begin
      if (out_last) begin
        cnt_d  = 2'd0;
        head_d = 2'd0;
      end else begin
        head_d = head_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      pstart_q <= '0;
      lsf_q    <= 1'b1;
      pls_q    <= 1'b0;
      dopen_q  <= 1'b0;
      dbeg_q   <= '0;
      ntok_q   <= '0;
      kwc_q    <= '0;
      ilen_q   <= '0;
      dir_en_q <= 1'b1;
      cnt_q    <= 2'd0;
      head_q   <= 2'd0;
    end else begin
      if (in_take) begin
        mode_q   <= mode_d;
        pos_q    <= pos_d;
        pstart_q <= pstart_d;
        lsf_q    <= lsf_d;
        pls_q    <= pls_d;
        dopen_q  <= dopen_d;
        dbeg_q   <= dbeg_d;
        ntok_q   <= ntok_d;
        kwc_q    <= kwc_d;
        ilen_q   <= ilen_d;
      end
      if (cfg_valid_i && cfg_ready_o) dir_en_q <= cfg_data_i;
      cnt_q  <= cnt_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      for (int i = 0; i < cltok_pkg::RESULT_SLOTS; i++) res_q[i] <= res_d[i];
    end
  end

  assign out_res            = res_q[head_q];
  assign result_kind_o      = out_res.kind;
  assign token_kind_o       = out_res.tkind;
  assign punctuation_code_o = out_res.pcode;
  assign start_offset_o     = 32'(out_res.start);
  assign span_length_o      = 32'(out_res.len);
  assign at_line_start_o    = out_res.bol;
  assign directive_first_o  = 32'(out_res.dfirst);
  assign directive_end_o    = 32'(out_res.dend);
  assign error_code_o       = out_res.ecode;
  assign last_o             = out_last;

  `TOK_ASSERT(a_head_in_range, cnt_q == 2'd0 || head_q < cnt_q, "result read pointer past fill")
  `TOK_ASSERT_NEXT(a_halt_silent, in_take && !end_of_source_i && mode_q == MODE_HALT,
                   !out_valid_o, "halted scanner produced a result")
  `TOK_ASSERT_NEXT(a_end_clears, in_take && end_of_source_i,
                   mode_q == MODE_IDLE && pos_q == '0 && ntok_q == '0 && !dopen_q,
                   "end item did not clear scanner state")

endmodule

`default_nettype wire

>>> dv/tb_c_like_source_tokenizer.sv
// self-checking testbench for c_like_source_tokenizer: directed sources, then random
// token streams under several idle and stall mixes; depends on cltok_pkg and the rtl
module tb_c_like_source_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned PHASE_ITEMS  = 104;
  localparam int          OB           = cltok_pkg::OFFSET_BITS;
  localparam int          TIB          = cltok_pkg::TOKEN_INDEX_BITS;

  typedef struct packed {
    cltok_pkg::result_t res;
    logic               last;
  } tok_out_t;

  class token_stream_checker;
    typedef enum {
      SC_IDLE, SC_IDENT, SC_INT, SC_STRING, SC_SLASH, SC_LINE, SC_BLOCK, SC_BSTAR, SC_HALT
    } scan_e;

    string                  kw_word[4] = '{"namespace", "enum", "class", "struct"};
    cltok_pkg::token_kind_e kw_kind[4] = '{cltok_pkg::TK_NAMESPACE, cltok_pkg::TK_ENUM,
                                           cltok_pkg::TK_CLASS, cltok_pkg::TK_STRUCT};
    string                  punct_set  = "{};:,=+-#&*[]";

    tok_out_t expected_tokens[$];
    int unsigned fail_count;

    logic           dir_en;
    scan_e          mode;
    logic [OB-1:0]  pos;
    logic [OB-1:0]  tok_start;
    logic           at_bol;
    logic           tok_bol;
    logic           dir_open;
    logic [TIB-1:0] dir_first;
    logic [TIB-1:0] tok_count;
    logic [3:0]     kw_mask;
    logic [3:0]     id_len;

    function new();
      dir_en = 1'b1;
      fail_count = 0;
      reset_source();
    endfunction

    function void reset_source();
      mode = SC_IDLE;
      pos = '0;
      tok_start = '0;
      at_bol = 1'b1;
      tok_bol = 1'b0;
      dir_open = 1'b0;
      dir_first = '0;
      tok_count = '0;
      kw_mask = '0;
      id_len = '0;
    endfunction

    function void set_directives(logic en);
      dir_en = en;
    endfunction

    function int unsigned pending();
      return expected_tokens.size();
    endfunction

    function void push_result(cltok_pkg::result_kind_e k, cltok_pkg::token_kind_e tk,
                              logic [3:0] pc, logic [31:0] so, logic [31:0] sl, logic ls,
                              logic [31:0] df, logic [31:0] de, cltok_pkg::error_code_e ec);
      tok_out_t e;
      e.res.kind = k;
      e.res.tkind = tk;
      e.res.pcode = pc;
      e.res.start = so;
      e.res.len = sl;
      e.res.bol = ls;
      e.res.dfirst = df;
      e.res.dend = de;
      e.res.ecode = ec;
      e.last = 1'b0;
      expected_tokens = {expected_tokens, e};
    endfunction

    function void emit_token(cltok_pkg::token_kind_e tk, logic [3:0] pc, logic [31:0] so,
                             logic [31:0] sl, logic ls);
      push_result(cltok_pkg::RK_TOKEN, tk, pc, so, sl, ls, '0, '0, cltok_pkg::EC_INVALID);
      tok_count = tok_count + TIB'(1);
    endfunction

    function void raise_error(cltok_pkg::error_code_e ec, logic [31:0] so, logic [31:0] sl);
      push_result(cltok_pkg::RK_ERROR, cltok_pkg::TK_IDENT, cltok_pkg::PC_NONE, so, sl, 1'b0,
                  '0, '0, ec);
      mode = SC_HALT;
    endfunction

    function void close_directive();
      if (dir_open && dir_en)
        push_result(cltok_pkg::RK_SPAN, cltok_pkg::TK_IDENT, cltok_pkg::PC_NONE, '0, '0, 1'b0,
                    dir_first, tok_count, cltok_pkg::EC_INVALID);
      dir_open = 1'b0;
    endfunction

    function bit is_word_start(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    // drop keywords that the identifier no longer matches
    function void ident_add(logic [7:0] c);
      int k;
      for (k = 0; k < 4; k++)
        if (kw_mask[k] && (id_len >= kw_word[k].len() || kw_word[k][id_len] != c))
          kw_mask[k] = 1'b0;
      if (id_len < 4'd15) id_len = id_len + 4'd1;
    endfunction

    function void finish_word();
      cltok_pkg::token_kind_e kind;
      int k;
      kind = cltok_pkg::TK_INT;
      if (mode == SC_IDENT) begin
        kind = cltok_pkg::TK_IDENT;
        for (k = 0; k < 4; k++)
          if (kw_mask[k] && id_len == kw_word[k].len()) kind = kw_kind[k];
      end
      emit_token(kind, cltok_pkg::PC_NONE, tok_start, pos - tok_start, tok_bol);
      mode = SC_IDLE;
    endfunction

    function void idle_byte(logic [7:0] c);
      int i;
      if (c == cltok_pkg::CH_SPACE || c == cltok_pkg::CH_TAB || c == cltok_pkg::CH_CR) return;
      if (c == cltok_pkg::CH_LF) begin
        close_directive();
        at_bol = 1'b1;
        return;
      end
      if (c == cltok_pkg::CH_SLASH) begin
        mode = SC_SLASH;
        tok_start = pos;
        return;
      end
      tok_start = pos;
      tok_bol = at_bol;
      if (is_word_start(c)) begin
        at_bol = 1'b0;
        mode = SC_IDENT;
        kw_mask = 4'hf;
        id_len = '0;
        ident_add(c);
        return;
      end
      if (is_digit(c)) begin
        at_bol = 1'b0;
        mode = SC_INT;
        return;
      end
      if (c == cltok_pkg::CH_QUOTE) begin
        at_bol = 1'b0;
        mode = SC_STRING;
        return;
      end
      for (i = 0; i < 13; i++) begin
        if (punct_set[i] == c) begin
          at_bol = 1'b0;
          // a hash that opens its line starts a directive when directives are enabled
          if (4'(i + 1) == cltok_pkg::PC_HASH && tok_bol && dir_en) begin
            dir_first = tok_count;
            dir_open = 1'b1;
          end
          emit_token(cltok_pkg::TK_PUNCT, 4'(i + 1), pos, 32'd1, tok_bol);
          return;
        end
      end
      raise_error(cltok_pkg::EC_INVALID, pos, 32'd1);
    endfunction

    function void note_source_item(logic [7:0] c, logic eos);
      int unsigned n0;
      n0 = expected_tokens.size();
      if (eos) begin
        case (mode)
          SC_IDENT, SC_INT:  finish_word();
          SC_STRING:         raise_error(cltok_pkg::EC_STRING, tok_start, pos - tok_start);
          SC_SLASH:          raise_error(cltok_pkg::EC_INVALID, tok_start, 32'd1);
          SC_BLOCK, SC_BSTAR: raise_error(cltok_pkg::EC_COMMENT, tok_start, pos - tok_start);
          default: ;
        endcase
        if (mode != SC_HALT) begin
          close_directive();
          emit_token(cltok_pkg::TK_EOF, cltok_pkg::PC_NONE, pos, '0, 1'b0);
        end
        reset_source();
      end else if (mode != SC_HALT) begin
        if (pos >= cltok_pkg::OFFSET_MAX) begin
          raise_error(cltok_pkg::EC_OVERFLOW, '0, '0);
        end else begin
          case (mode)
            SC_IDENT: begin
              if (is_word_start(c) || is_digit(c)) ident_add(c);
              else begin
                finish_word();
                idle_byte(c);
              end
            end
            SC_INT: begin
              if (!is_digit(c)) begin
                finish_word();
                idle_byte(c);
              end
            end
            SC_STRING: begin
              if (c == cltok_pkg::CH_QUOTE) begin
                mode = SC_IDLE;
                emit_token(cltok_pkg::TK_STRING, cltok_pkg::PC_NONE, tok_start,
                           pos + OB'(1) - tok_start, tok_bol);
              end else if (c == cltok_pkg::CH_LF) begin
                raise_error(cltok_pkg::EC_STRING, tok_start, pos - tok_start);
              end
            end
            SC_SLASH: begin
              if (c == cltok_pkg::CH_SLASH) mode = SC_LINE;
              else if (c == cltok_pkg::CH_STAR) mode = SC_BLOCK;
              else raise_error(cltok_pkg::EC_INVALID, tok_start, 32'd1);
            end
            SC_LINE: begin
              if (c == cltok_pkg::CH_LF) begin
                mode = SC_IDLE;
                idle_byte(c);
              end
            end
            SC_BLOCK, SC_BSTAR: begin
              if (mode == SC_BSTAR && c == cltok_pkg::CH_SLASH) mode = SC_IDLE;
              else if (c == cltok_pkg::CH_STAR) mode = SC_BSTAR;
              else begin
                if (c == cltok_pkg::CH_LF) at_bol = 1'b1;
                mode = SC_BLOCK;
              end
            end
            default: idle_byte(c);
          endcase
          pos = pos + OB'(1);
        end
      end
      if (expected_tokens.size() > n0) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    function string show(tok_out_t t);
      return $sformatf({"kind=%0d tok=%0d punct=%0d start=%0d len=%0d bol=%0b ",
                        "first=%0d end=%0d err=%0d last=%0b"},
                       t.res.kind, t.res.tkind, t.res.pcode, t.res.start, t.res.len,
                       t.res.bol, t.res.dfirst, t.res.dend, t.res.ecode, t.last);
    endfunction

    function void report(string what);
      fail_count++;
      if (fail_count <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_token(tok_out_t got);
      tok_out_t want;
      if (expected_tokens.size() == 0) begin
        report({"result with nothing expected: ", show(got)});
        return;
      end
      want = expected_tokens.pop_front();
      if (got !== want) report({"expected ", show(want), " got ", show(got)});
    endfunction

    function void drain_check();
      if (expected_tokens.size() != 0)
        report($sformatf("%0d results never came, oldest %s", expected_tokens.size(),
                         show(expected_tokens[0])));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        end_of_source_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [3:0]  token_kind_o;
  logic [3:0]  punctuation_code_o;
  logic [31:0] start_offset_o;
  logic [31:0] span_length_o;
  logic        at_line_start_o;
  logic [31:0] directive_first_o;
  logic [31:0] directive_end_o;
  logic [1:0]  error_code_o;
  logic        last_o;

  token_stream_checker sb;
  string       word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  logic [8:0]  src_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          pressure_req = 1'b0;
  bit          hold_active = 1'b0;
  int unsigned idle_cycles = 0;

  c_like_source_tokenizer i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .end_of_source_i    (end_of_source_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_kind_o      (result_kind_o),
    .token_kind_o       (token_kind_o),
    .punctuation_code_o (punctuation_code_o),
    .start_offset_o     (start_offset_o),
    .span_length_o      (span_length_o),
    .at_line_start_o    (at_line_start_o),
    .directive_first_o  (directive_first_o),
    .directive_end_o    (directive_end_o),
    .error_code_o       (error_code_o),
    .last_o             (last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= hold_active || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off so the result buffer fills and the input stalls
  initial begin
    wait (pressure_req);
    @(posedge clk_i);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active = 1'b0;
  end

  always @(posedge clk_i) begin
    tok_out_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.res.kind = cltok_pkg::result_kind_e'(result_kind_o);
      got.res.tkind = cltok_pkg::token_kind_e'(token_kind_o);
      got.res.pcode = punctuation_code_o;
      got.res.start = start_offset_o;
      got.res.len = span_length_o;
      got.res.bol = at_line_start_o;
      got.res.dfirst = directive_first_o;
      got.res.dend = directive_end_o;
      got.res.ecode = cltok_pkg::error_code_e'(error_code_o);
      got.last = last_o;
      sb.check_token(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_item(logic [7:0] b, logic eos);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    end_of_source_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_source_item(b, eos);
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic write_directives(logic en);
    release_input();
    while (sb.pending() != 0) @(posedge clk_i);
    // an item with no result may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= en;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_directives(en);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] word_char(bit first);
    return word_chars[first ? $urandom_range(52) : $urandom_range(62)];
  endfunction

  function automatic void queue_src(logic [8:0] v);
    src_q = {src_q, v};
  endfunction

  // one random source fragment, mostly well formed
  function automatic void add_fragment();
    int unsigned r, n, k, variant, i;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 15) begin
      k = $urandom_range(3);
      variant = $urandom_range(3);
      n = sb.kw_word[k].len();
      if (variant == 0) n = $urandom_range(n - 1, 1);
      for (i = 0; i < n; i++) queue_src({1'b0, sb.kw_word[k][i]});
      if (variant == 1) queue_src({1'b0, word_char(1'b0)});
      if (variant == 2) src_q[src_q.size() - 1] = {1'b0, word_char(1'b1)};
      if ($urandom_range(9) < 7) queue_src({1'b0, cltok_pkg::CH_SPACE});
    end else if (r < 30) begin
      n = $urandom_range(17, 1);
      queue_src({1'b0, word_char(1'b1)});
      for (i = 1; i < n; i++) queue_src({1'b0, word_char(1'b0)});
      if ($urandom_range(9) < 7) queue_src({1'b0, cltok_pkg::CH_SPACE});
    end else if (r < 40) begin
      n = $urandom_range(6, 1);
      for (i = 0; i < n; i++) queue_src({1'b0, word_chars[$urandom_range(62, 53)]});
      if ($urandom_range(9) < 7) queue_src({1'b0, cltok_pkg::CH_SPACE});
    end else if (r < 48) begin
      queue_src({1'b0, cltok_pkg::CH_QUOTE});
      n = $urandom_range(5);
      for (i = 0; i < n; i++) begin
        c = 8'($urandom_range(8'h7e, 8'h20));
        if (c == cltok_pkg::CH_QUOTE) c = "x";
        queue_src({1'b0, c});
      end
      variant = $urandom_range(19);
      if (variant == 0) queue_src({1'b0, cltok_pkg::CH_LF});
      else if (variant == 1) queue_src({1'b1, 8'($urandom_range(255))});
      else queue_src({1'b0, cltok_pkg::CH_QUOTE});
    end else if (r < 63) begin
      queue_src({1'b0, sb.punct_set[$urandom_range(12)]});
    end else if (r < 73) begin
      n = $urandom_range(3, 1);
      for (i = 0; i < n; i++) begin
        k = $urandom_range(2);
        queue_src({1'b0, (k == 0) ? cltok_pkg::CH_SPACE :
                         (k == 1) ? cltok_pkg::CH_TAB : cltok_pkg::CH_CR});
      end
    end else if (r < 81) begin
      queue_src({1'b0, cltok_pkg::CH_LF});
      if ($urandom_range(1)) queue_src({1'b0, 8'h23});
    end else if (r < 86) begin
      queue_src({1'b0, cltok_pkg::CH_SLASH});
      queue_src({1'b0, cltok_pkg::CH_SLASH});
      n = $urandom_range(4);
      for (i = 0; i < n; i++) begin
        c = 8'($urandom_range(255));
        if (c == cltok_pkg::CH_LF) c = cltok_pkg::CH_SPACE;
        queue_src({1'b0, c});
      end
      queue_src({1'b0, cltok_pkg::CH_LF});
    end else if (r < 91) begin
      queue_src({1'b0, cltok_pkg::CH_SLASH});
      queue_src({1'b0, cltok_pkg::CH_STAR});
      n = $urandom_range(5);
      for (i = 0; i < n; i++) begin
        k = $urandom_range(2);
        queue_src({1'b0, (k == 0) ? 8'($urandom_range(255)) :
                         (k == 1) ? cltok_pkg::CH_STAR : cltok_pkg::CH_LF});
      end
      if ($urandom_range(9) == 0) begin
        queue_src({1'b1, 8'($urandom_range(255))});
      end else begin
        queue_src({1'b0, cltok_pkg::CH_STAR});
        queue_src({1'b0, cltok_pkg::CH_SLASH});
      end
    end else if (r < 95) begin
      queue_src({1'b1, 8'($urandom_range(255))});
    end else begin
      // noise or a slash before an arbitrary byte
      if ($urandom_range(1)) queue_src({1'b0, cltok_pkg::CH_SLASH});
      queue_src({1'b0, 8'($urandom_range(255))});
      if ($urandom_range(1)) queue_src({1'b1, 8'($urandom_range(255))});
    end
  endfunction

  task automatic run_phase(int unsigned idle_pct, int unsigned hold_pct, logic en,
                           int unsigned target);
    int unsigned done;
    logic [8:0] it;
    write_directives(en);
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    done = 0;
    while (done < target) begin
      if (src_q.size() == 0) add_fragment();
      it = src_q.pop_front();
      done++;
      send_item(it[7:0], it[8]);
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_text("#x{};:,=+-&*[]\n");
    send_end();
    send_text("9/");
    send_end();
    send_text("\"a\n");
    send_end();
    send_text("\"");
    send_end();
    send_text("/*");
    send_end();
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_end();
    // directive left open while tracking is switched off
    send_text("#q");
    write_directives(1'b0);
    send_text("\n");
    send_end();

    pressure_req = 1'b1;
    run_phase(0, 0, 1'b1, PHASE_ITEMS);
    run_phase(56, 0, 1'b0, PHASE_ITEMS);
    run_phase(0, 56, 1'b1, PHASE_ITEMS);
    run_phase(11, 11, 1'b0, PHASE_ITEMS);

    release_input();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4 * DRAIN_CYCLES) @(posedge clk_i);
    sb.drain_check();
    if (sb.fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
